/* design/ttw_pkg.sv */
// ----------------------------------------------------------------------------
// ttw_pkg: shared types and constants of the text terminal writer
// Character codes, request kinds, register indexes and cell layout.
// ----------------------------------------------------------------------------
package ttw_pkg;

   // request kinds on req_type
   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // configuration register indexes
   localparam logic CSR_BACKGROUND = 1'b0;
   localparam logic CSR_FOREGROUND = 1'b1;

   // character codes with special meaning
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_TAB     = 8'd9;
   localparam logic [7:0] CODE_SPACE   = 8'd32;

   // tab advance in columns
   localparam int unsigned TAB_STEP = 3;

   // colors after reset
   localparam logic [3:0] RESET_BACKGROUND = 4'd0;
   localparam logic [3:0] RESET_FOREGROUND = 4'd7;

   // screen cell after reset: space in reset colors
   localparam logic [15:0] RESET_CELL = {RESET_BACKGROUND, RESET_FOREGROUND, CODE_SPACE};

   // build a cell from colors and code
   function automatic logic [15:0] make_cell(input logic [3:0] bg,
                                             input logic [3:0] fg,
                                             input logic [7:0] code);
      make_cell = {bg, fg, code};
   endfunction

endpackage

/* design/text_terminal_writer_core.sv */
// ----------------------------------------------------------------------------
// text_terminal_writer_core: character-cell text screen with a cursor
// Puts characters at the cursor, handles newline, tab, wrap and scroll, and
// reads displayed cells back from a single-port screen memory.
// ----------------------------------------------------------------------------
// Steps: a put passes the address step (CALC), the memory write (WRITE) and
// the cursor step (MOVE), and one that scrolls then blanks a row (SCROLL); an
// in-range read passes CALC, READ and READOUT, an out-of-range read answers
// from CALC. A new transaction is taken only after the last has answered;
// busy is high meanwhile. The receiver cannot stall.
// Reset: clears the screen to spaces in reset colors once reset is released.
module text_terminal_writer_core #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_address,
   // result channel
   output logic        rsp_strobe,
   output logic [15:0] rsp_cell_data,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_column,
   output logic        rsp_scrolled,
   // configuration port
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [3:0]  csr_write_data
);

   localparam int unsigned CELLS = ROWS * COLUMNS;
   localparam int unsigned AW    = $clog2(CELLS);
   localparam int unsigned SW    = AW + 1;
   localparam int unsigned LW    = (SW > 11) ? SW : 11;
   localparam int unsigned RW    = $clog2(ROWS);
   localparam int unsigned CW    = $clog2(COLUMNS + ttw_pkg::TAB_STEP);
   localparam int unsigned NW    = $clog2(COLUMNS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_WRITE,
      ST_MOVE,
      ST_SCROLL,
      ST_READ,
      ST_READOUT
   } state_type;

   state_type      state_ff;
   logic [AW-1:0]  addr_ff;
   logic [AW-1:0]  top_base_ff;
   logic [AW-1:0]  row_base_ff;
   logic [RW-1:0]  row_ff;
   logic [CW-1:0]  col_ff;
   logic [NW-1:0]  cnt_ff;
   logic [3:0]     bg_ff;
   logic [3:0]     fg_ff;
   logic           req_type_ff;
   logic           in_range_ff;
   logic [7:0]     code_ff;
   logic           strobe_ff;
   logic [15:0]    data_ff;
   logic [4:0]     orow_ff;
   logic [6:0]     ocol_ff;
   logic           scrolled_ff;

   // screen memory
   logic [15:0]    mem [CELLS];
   logic [15:0]    rdata_ff;
   logic           mem_we;
   logic [15:0]    mem_wdata;

   // address step: displayed address plus top offset, folded into the screen
   logic [SW-1:0]  sum;
   logic [AW-1:0]  phys_addr;

   // cursor step
   logic [CW-1:0]  col_step;
   logic           wrap;
   logic           is_newline;
   logic           is_tab;
   logic           printable;
   logic [LW-1:0]  addr_wide;
   logic [AW-1:0]  top_next;

   assign addr_wide  = LW'(req_cell_address);
   assign sum        = SW'(addr_ff) + SW'(top_base_ff);
   assign phys_addr  = (sum >= SW'(CELLS)) ? AW'(sum - SW'(CELLS)) : AW'(sum);
   assign is_newline = (code_ff == ttw_pkg::CODE_NEWLINE);
   assign is_tab     = (code_ff == ttw_pkg::CODE_TAB);
   assign printable  = !is_newline && !is_tab;
   assign top_next   = (top_base_ff == AW'(CELLS - COLUMNS)) ? '0
                                                              : top_base_ff + AW'(COLUMNS);

   // next column before the wrap test
   always_comb begin
      if (is_newline) begin
         col_step = '0;
      end else if (is_tab) begin
         col_step = col_ff + CW'(ttw_pkg::TAB_STEP);
      end else begin
         col_step = col_ff + CW'(1);
      end
   end

   assign wrap = is_newline || (col_step >= CW'(COLUMNS));

   // memory write select: clear pass, scroll blanking or a character
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = ttw_pkg::make_cell(bg_ff, fg_ff, code_ff);
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = ttw_pkg::RESET_CELL;
         end
         ST_SCROLL: begin
            mem_we    = 1'b1;
            mem_wdata = ttw_pkg::make_cell(bg_ff, fg_ff, ttw_pkg::CODE_SPACE);
         end
         ST_WRITE: begin
            mem_we = printable;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // single port: write or read at addr_ff, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   // sequencer, cursor, colors and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         addr_ff     <= '0;
         top_base_ff <= '0;
         row_base_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         cnt_ff      <= '0;
         bg_ff       <= ttw_pkg::RESET_BACKGROUND;
         fg_ff       <= ttw_pkg::RESET_FOREGROUND;
         strobe_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;

         // take configuration writes at any time
         if (csr_write_enable) begin
            unique case (csr_index)
               ttw_pkg::CSR_BACKGROUND: bg_ff <= csr_write_data;
               ttw_pkg::CSR_FOREGROUND: fg_ff <= csr_write_data;
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_CLEAR: begin
               if (addr_ff == AW'(CELLS - 1)) begin
                  state_ff <= ST_IDLE;
               end
               addr_ff <= addr_ff + AW'(1);
            end
            ST_IDLE: begin
               if (start) begin
                  req_type_ff <= req_type;
                  code_ff     <= req_char_code;
                  in_range_ff <= (addr_wide < LW'(CELLS));
                  if (req_type == ttw_pkg::REQ_READ) begin
                     addr_ff <= AW'(addr_wide);
                  end else begin
                     addr_ff <= row_base_ff + AW'(col_ff);
                  end
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               addr_ff <= phys_addr;
               if (req_type_ff == ttw_pkg::REQ_PUT) begin
                  state_ff <= ST_WRITE;
               end else if (in_range_ff) begin
                  state_ff <= ST_READ;
               end else begin
                  // out-of-range read: answer zero at once
                  data_ff     <= '0;
                  orow_ff     <= 5'(row_ff);
                  ocol_ff     <= 7'(col_ff);
                  scrolled_ff <= 1'b0;
                  strobe_ff   <= 1'b1;
                  state_ff    <= ST_IDLE;
               end
            end
            ST_WRITE: begin
               state_ff <= ST_MOVE;
            end
            ST_MOVE: begin
               data_ff <= '0;
               if (!wrap) begin
                  col_ff      <= col_step;
                  orow_ff     <= 5'(row_ff);
                  ocol_ff     <= 7'(col_step);
                  scrolled_ff <= 1'b0;
                  strobe_ff   <= 1'b1;
                  state_ff    <= ST_IDLE;
               end else if (row_ff == RW'(ROWS - 1)) begin
                  // scroll: advance the top offset, then blank the old top row
                  col_ff      <= '0;
                  addr_ff     <= top_base_ff;
                  top_base_ff <= top_next;
                  cnt_ff      <= '0;
                  state_ff    <= ST_SCROLL;
               end else begin
                  col_ff      <= '0;
                  row_ff      <= row_ff + RW'(1);
                  row_base_ff <= row_base_ff + AW'(COLUMNS);
                  orow_ff     <= 5'(row_ff + RW'(1));
                  ocol_ff     <= '0;
                  scrolled_ff <= 1'b0;
                  strobe_ff   <= 1'b1;
                  state_ff    <= ST_IDLE;
               end
            end
            ST_SCROLL: begin
               addr_ff <= addr_ff + AW'(1);
               cnt_ff  <= cnt_ff + NW'(1);
               if (cnt_ff == NW'(COLUMNS - 1)) begin
                  orow_ff     <= 5'(row_ff);
                  ocol_ff     <= 7'(col_ff);
                  scrolled_ff <= 1'b1;
                  strobe_ff   <= 1'b1;
                  state_ff    <= ST_IDLE;
               end
            end
            ST_READ: begin
               state_ff <= ST_READOUT;
            end
            ST_READOUT: begin
               data_ff     <= rdata_ff;
               orow_ff     <= 5'(row_ff);
               ocol_ff     <= 7'(col_ff);
               scrolled_ff <= 1'b0;
               strobe_ff   <= 1'b1;
               state_ff    <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_cell_data     = data_ff;
   assign rsp_cursor_row    = orow_ff;
   assign rsp_cursor_column = ocol_ff;
   assign rsp_scrolled      = scrolled_ff;

endmodule

/* tb/tb_text_terminal_writer_core.sv */
// ----------------------------------------------------------------------------
// tb_text_terminal_writer_core: self-checking bench of the text terminal writer
// Drives puts and reads through the command port, rewrites the colors between
// phases, and checks every response against a cycle-free model of the screen.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_terminal_writer_core;

   localparam int unsigned COLUMNS      = 80;
   localparam int unsigned ROWS         = 25;
   localparam int unsigned SCREEN_CELLS = COLUMNS * ROWS;
   localparam int unsigned RESET_CYCLES = 12;
   // longest response: put with scroll blanks a whole row, plus margin
   localparam int unsigned SETTLE_CYCLES = COLUMNS + 16;
   // covers the clearing pass after reset and the longest sender gap
   localparam int unsigned WATCHDOG_LIMIT = 10000;

   typedef struct packed {
      logic [15:0] cell_data;
      logic [4:0]  row;
      logic [6:0]  column;
      logic        scrolled;
   } screen_response_type;

   // --------------------------------------------------------------------------
   // Screen model and store of expected responses
   // --------------------------------------------------------------------------
   class screen_scoreboard;
      logic [15:0]         cells [SCREEN_CELLS];
      int unsigned         top_row;
      int unsigned         cur_row;
      int unsigned         cur_col;
      logic [3:0]          bg_color;
      logic [3:0]          fg_color;
      screen_response_type expected_responses[$];
      int unsigned         errors;

      function new();
         bg_color = ttw_pkg::RESET_BACKGROUND;
         fg_color = ttw_pkg::RESET_FOREGROUND;
         top_row  = 0;
         cur_row  = 0;
         cur_col  = 0;
         errors   = 0;
         foreach (cells[i]) cells[i] = ttw_pkg::RESET_CELL;
      endfunction

      function void write_color(logic index, logic [3:0] value);
         if (index == ttw_pkg::CSR_BACKGROUND) bg_color = value;
         else fg_color = value;
      endfunction

      function int unsigned pending();
         return expected_responses.size();
      endfunction

      // advance the screen by one accepted transaction and queue its response
      function void apply_request(logic kind, logic [7:0] code, logic [10:0] addr);
         screen_response_type res;
         int unsigned         prow;
         int unsigned         vacated;
         int unsigned         col;
         res = '0;
         if (kind == ttw_pkg::REQ_READ) begin
            if (addr < SCREEN_CELLS) begin
               prow = (addr / COLUMNS + top_row) % ROWS;
               res.cell_data = cells[prow * COLUMNS + addr % COLUMNS];
            end
         end else begin
            if (code == ttw_pkg::CODE_NEWLINE) begin
               cur_row++;
               cur_col = 0;
            end else if (code == ttw_pkg::CODE_TAB) begin
               cur_col += ttw_pkg::TAB_STEP;
            end else begin
               prow = (cur_row + top_row) % ROWS;
               cells[prow * COLUMNS + cur_col] = {bg_color, fg_color, code};
               cur_col++;
            end
            // wrap at the right edge, tabs drop any overshoot
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row++;
            end
            // scroll: old top row becomes the blank bottom row
            if (cur_row >= ROWS) begin
               vacated = top_row;
               top_row = (top_row + 1) % ROWS;
               for (col = 0; col < COLUMNS; col++)
                  cells[vacated * COLUMNS + col] = {bg_color, fg_color, ttw_pkg::CODE_SPACE};
               cur_row = ROWS - 1;
               res.scrolled = 1'b1;
            end
         end
         res.row    = 5'(cur_row);
         res.column = 7'(cur_col);
         expected_responses.push_back(res);
      endfunction

      function void report_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // compare one response with the oldest expectation
      function void check_response(screen_response_type got);
         screen_response_type want;
         if (expected_responses.size() == 0) begin
            errors++;
            $display("%0t: response with no transaction pending, actual %h", $time, got);
            return;
         end
         want = expected_responses.pop_front();
         report_field("cell_data", want.cell_data, got.cell_data);
         report_field("cursor_row", want.row, got.row);
         report_field("cursor_column", want.column, got.column);
         report_field("scrolled", want.scrolled, got.scrolled);
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // Signals and instance
   // --------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_type;
   logic [7:0]  req_char_code;
   logic [10:0] req_cell_address;
   logic        rsp_strobe;
   logic [15:0] rsp_cell_data;
   logic [4:0]  rsp_cursor_row;
   logic [6:0]  rsp_cursor_column;
   logic        rsp_scrolled;
   logic        csr_write_enable;
   logic        csr_index;
   logic [3:0]  csr_write_data;

   screen_scoreboard sb;
   int unsigned      idle_pct;
   int unsigned      quiet_cycles;

   text_terminal_writer_core #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_char_code    (req_char_code),
      .req_cell_address (req_cell_address),
      .rsp_strobe       (rsp_strobe),
      .rsp_cell_data    (rsp_cell_data),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_column(rsp_cursor_column),
      .rsp_scrolled     (rsp_scrolled),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // check each response in the cycle it is presented
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_response({rsp_cell_data, rsp_cursor_row, rsp_cursor_column, rsp_scrolled});
   end

   // end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("text_terminal_writer_core test failed");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Drivers: entered and left at a falling edge
   // --------------------------------------------------------------------------
   task automatic send_item(input logic kind, input logic [7:0] code, input logic [10:0] addr);
      // hold off at random before the transaction
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start            = 1'b1;
      req_type         = kind;
      req_char_code    = code;
      req_cell_address = addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.apply_request(kind, code, addr);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_color(input logic index, input logic [3:0] value);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.write_color(index, value);
   endtask

   task automatic send_read_near_cursor();
      int unsigned row;
      if ($urandom_range(7) == 0) begin
         send_item(ttw_pkg::REQ_READ, 8'($urandom_range(255)), 11'($urandom_range(2047)));
      end else begin
         row = sb.cur_row - $urandom_range(0, (sb.cur_row < 3) ? sb.cur_row : 3);
         send_item(ttw_pkg::REQ_READ, 8'($urandom_range(255)),
                   11'(row * COLUMNS + $urandom_range(COLUMNS - 1)));
      end
   endtask

   // mostly lines of text with tabs, read-backs and newline runs; some noise
   task automatic random_traffic(input int unsigned item_count);
      int unsigned sent;
      int unsigned burst;
      int unsigned pick;
      sent = 0;
      while (sent < item_count) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            burst = $urandom_range(1, 100);
            repeat (burst) begin
               if ($urandom_range(9) == 0)
                  send_item(ttw_pkg::REQ_PUT, ttw_pkg::CODE_TAB,
                            11'($urandom_range(2047)));
               else if ($urandom_range(19) == 0)
                  send_item(ttw_pkg::REQ_PUT, 8'($urandom_range(255)),
                            11'($urandom_range(2047)));
               else
                  send_item(ttw_pkg::REQ_PUT, 8'($urandom_range(32, 126)),
                            11'($urandom_range(2047)));
            end
            if ($urandom_range(1) == 1) begin
               send_item(ttw_pkg::REQ_PUT, ttw_pkg::CODE_NEWLINE, 11'($urandom_range(2047)));
               burst++;
            end
         end else if (pick < 75) begin
            burst = $urandom_range(1, 8);
            repeat (burst) send_read_near_cursor();
         end else if (pick < 85) begin
            burst = $urandom_range(1, 30);
            repeat (burst)
               send_item(ttw_pkg::REQ_PUT, ttw_pkg::CODE_NEWLINE, 11'($urandom_range(2047)));
         end else if (pick < 97) begin
            burst = $urandom_range(1, 10);
            repeat (burst)
               send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                         11'($urandom_range(2047)));
         end else begin
            // let the block drain completely
            wait_drained();
            burst = 0;
         end
         sent += burst;
      end
   endtask

   // --------------------------------------------------------------------------
   // Test sequence
   // --------------------------------------------------------------------------
   initial begin
      sb               = new();
      idle_pct         = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_type         = ttw_pkg::REQ_PUT;
      req_char_code    = '0;
      req_cell_address = '0;
      csr_write_enable = 1'b0;
      csr_index        = ttw_pkg::CSR_BACKGROUND;
      csr_write_data   = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // directed: code extremes, newline, tab, reads at the address extremes
      send_item(ttw_pkg::REQ_PUT, 8'h41, '0);
      send_item(ttw_pkg::REQ_PUT, 8'h00, 11'h7FF);
      send_item(ttw_pkg::REQ_PUT, 8'hFF, '0);
      send_item(ttw_pkg::REQ_PUT, 8'h80, '0);
      send_item(ttw_pkg::REQ_PUT, 8'h7F, '0);
      send_item(ttw_pkg::REQ_PUT, ttw_pkg::CODE_TAB, '0);
      send_item(ttw_pkg::REQ_PUT, ttw_pkg::CODE_SPACE, '0);
      send_item(ttw_pkg::REQ_PUT, ttw_pkg::CODE_NEWLINE, '0);
      send_item(ttw_pkg::REQ_PUT, 8'h5A, '0);
      send_item(ttw_pkg::REQ_READ, 8'hFF, 11'd0);
      send_item(ttw_pkg::REQ_READ, 8'h00, 11'd1);
      send_item(ttw_pkg::REQ_READ, ttw_pkg::CODE_NEWLINE, 11'd3);
      send_item(ttw_pkg::REQ_READ, ttw_pkg::CODE_TAB, 11'd6);
      send_item(ttw_pkg::REQ_READ, 8'h00, 11'(COLUMNS));
      send_item(ttw_pkg::REQ_READ, 8'h00, 11'(SCREEN_CELLS - 1));
      send_item(ttw_pkg::REQ_READ, 8'h00, 11'(SCREEN_CELLS));
      send_item(ttw_pkg::REQ_READ, 8'h00, 11'h7FF);
      send_item(ttw_pkg::REQ_READ, 8'h00, 11'h400);
      send_item(ttw_pkg::REQ_PUT, ttw_pkg::CODE_NEWLINE, '0);
      send_item(ttw_pkg::REQ_PUT, ttw_pkg::CODE_TAB, '0);
      send_item(ttw_pkg::REQ_PUT, ttw_pkg::CODE_TAB, '0);

      // back-to-back traffic with extreme colors
      wait_drained();
      write_color(ttw_pkg::CSR_BACKGROUND, 4'hF);
      write_color(ttw_pkg::CSR_FOREGROUND, 4'h0);
      idle_pct = 0;
      random_traffic(450);

      // mostly idle sender, opposite extremes
      wait_drained();
      write_color(ttw_pkg::CSR_BACKGROUND, 4'h0);
      write_color(ttw_pkg::CSR_FOREGROUND, 4'hF);
      idle_pct = 83;
      random_traffic(450);

      // light idling, random colors
      wait_drained();
      write_color(ttw_pkg::CSR_BACKGROUND, 4'($urandom_range(15)));
      write_color(ttw_pkg::CSR_FOREGROUND, 4'($urandom_range(15)));
      idle_pct = 23;
      random_traffic(450);

      wait_drained();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("text_terminal_writer_core test passed");
      end else begin
         $display("text_terminal_writer_core test failed");
      end
      $finish;
   end

endmodule
